[rtl/tqle_pkg.sv]
// Shared constants for the tabular Q-learning engine.
`default_nettype none
package tqle_pkg;

  // command codes
  localparam logic [1:0] CMD_CHOOSE = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_EPEND  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_LEARN_RATE  = 2'd0;
  localparam logic [1:0] CFG_DISCOUNT    = 2'd1;
  localparam logic [1:0] CFG_MIN_EXPLORE = 2'd2;

  localparam logic [15:0] LEARN_RATE_RST  = 16'd6554;
  localparam logic [15:0] DISCOUNT_RST    = 16'd58982;
  localparam logic [15:0] MIN_EXPLORE_RST = 16'd655;
  localparam logic [15:0] EPSILON_RST     = 16'd6554;

  localparam int Q_W     = 32;
  localparam int MUL_A_W = 26;              // unsigned operand
  localparam int MUL_B_W = 34;              // signed operand
  localparam int MUL_P_W = MUL_A_W + 1 + MUL_B_W;

  // eps*995/1000 == eps*199/200; divide by 200 as multiply by ceil(2^32/200)
  localparam logic [MUL_A_W-1:0] DECAY_MUL   = 26'd199;
  localparam logic [MUL_A_W-1:0] DECAY_RECIP = 26'd21474837;
  localparam int                 DECAY_SHIFT = 32;

  localparam int PCT_SCALE = 100;

endpackage : tqle_pkg
`default_nettype wire

[rtl/tqle_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tqle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : tqle_ram
`default_nettype wire

[rtl/tabular_q_learning_engine_core.sv]
// Tabular Q-learning engine: two-action value table, epsilon-greedy choice, decay.
//
// Channels: in_* carries one command item (choose, update, end of episode);
// out_* returns exactly one result item per command; cfg_* writes alpha,
// gamma and the exploration floor, and may only be used while the block idles.
// All channels are valid/ready; cfg_ready is always high.
//
// After reset the value table is swept to zero, one entry a cycle, and the
// block holds in_ready low until every entry has been cleared.
//
// One item at a time, driven by a small sequencer around a single table read
// port and one shared 27x34 multiplier. Steps per command: choose reads both
// action values and picks; update does three table reads, two dependent
// multiplies and a write back; end of episode does two decay multiplies; an
// unused command goes straight to its result. in_ready rises together with
// out_valid, so a new item is accepted only once the sequencer is done.
//
// The output register lets the next item be accepted while a result waits;
// a stalled receiver holds the following result in the sequencer until the
// output register frees up.
`default_nettype none
module tabular_q_learning_engine_core
  import tqle_pkg::*;
#(
  parameter int NUM_STATES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [4:0]  in_cur_state,
  input  wire logic        in_taken_action,
  input  wire logic signed [15:0] in_reward_value,
  input  wire logic [4:0]  in_next_state,
  input  wire logic [6:0]  in_random_percent,
  input  wire logic        in_random_action,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_chosen_action,
  output logic             out_explored,
  output logic signed [31:0] out_q_result,
  output logic [15:0]      out_explore_rate,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int DEPTH = 2 * NUM_STATES;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD_A   = 4'd2;
  localparam logic [3:0] S_RD_B   = 4'd3;
  localparam logic [3:0] S_RD_C   = 4'd4;
  localparam logic [3:0] S_U_DIFF = 4'd5;
  localparam logic [3:0] S_U_MUL2 = 4'd6;
  localparam logic [3:0] S_U_WB   = 4'd7;
  localparam logic [3:0] S_C_PICK = 4'd8;
  localparam logic [3:0] S_D_MUL1 = 4'd9;
  localparam logic [3:0] S_D_MUL2 = 4'd10;
  localparam logic [3:0] S_D_FIN  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [15:0] learn_rate_r, discount_r, min_explore_r;
  logic [15:0] eps_r, eps_nxt;

  // latched item
  logic [1:0]        cmd_r;
  logic [SW-1:0]     cs_r, ns_r;
  logic              act_r, ract_r;
  logic signed [15:0] reward_r;
  logic [6:0]        rpct_r;

  // working registers
  logic signed [Q_W-1:0]     qa_r, qa_nxt;
  logic signed [Q_W-1:0]     old_r, old_nxt;
  logic signed [MUL_B_W-1:0] diff_r, diff_nxt;
  logic signed [MUL_P_W-1:0] p_r;
  logic                      res_act_r, res_act_nxt;
  logic                      res_exp_r, res_exp_nxt;
  logic signed [Q_W-1:0]     res_q_r, res_q_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_act_r, out_exp_r;
  logic signed [Q_W-1:0]     out_q_r;
  logic [15:0]               out_eps_r;
  logic                      out_load;

  // state index reduction: constant map of the 5-bit field
  logic [SW-1:0] st_map [32];
  for (genvar i = 0; i < 32; i++) begin : g_map
    assign st_map[i] = SW'(i % NUM_STATES);
  end

  // table port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [Q_W-1:0] ram_wdata, ram_rdata;
  logic signed [Q_W-1:0] rd_q;

  tqle_ram #(
    .WIDTH (Q_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_q = $signed(ram_rdata);

  // shared multiplier, registered product
  logic [MUL_A_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [Q_W-1:0]     best_q;

  assign best_q = (qa_r > rd_q) ? qa_r : rd_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_RD_C: begin
        mul_a = MUL_A_W'(discount_r);
        mul_b = MUL_B_W'(best_q);
      end
      S_U_MUL2: begin
        mul_a = MUL_A_W'(learn_rate_r);
        mul_b = diff_r;
      end
      S_D_MUL1: begin
        mul_a = DECAY_MUL;
        mul_b = $signed({{(MUL_B_W-16){1'b0}}, eps_r});
      end
      S_D_MUL2: begin
        mul_a = DECAY_RECIP;
        mul_b = $signed({{(MUL_B_W-24){1'b0}}, p_r[23:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= $signed({1'b0, mul_a}) * mul_b;
  end

  // round to Q16.16: floor((p + 2^15) / 2^16)
  logic signed [MUL_P_W-1:0] p_rnd;
  assign p_rnd = (p_r + MUL_P_W'(32768)) >>> 16;

  logic signed [MUL_B_W-1:0] reward_w, old_w;
  logic signed [35:0]        nv_w;
  logic signed [Q_W-1:0]     nv_sat;

  assign reward_w = $signed({{(MUL_B_W-24){reward_r[15]}}, reward_r, 8'd0});
  assign old_w    = MUL_B_W'(rd_q);
  assign nv_w     = $signed(p_rnd[35:0]) + 36'(old_r);

  always_comb begin
    priority if (nv_w > 36'sh07FFFFFFF) begin
      nv_sat = 32'sh7FFFFFFF;
    end else if (nv_w < -36'sh080000000) begin
      nv_sat = -32'sh80000000;
    end else begin
      nv_sat = nv_w[31:0];
    end
  end

  // exploration test and epsilon decay
  logic        explore;
  logic [15:0] eps_dec, eps_floor;
  assign explore   = {rpct_r, 16'd0} < (23'(eps_r) * 23'(PCT_SCALE));
  assign eps_dec   = (eps_r > min_explore_r) ? p_r[DECAY_SHIFT +: 16] : eps_r;
  assign eps_floor = (eps_dec < min_explore_r) ? min_explore_r : eps_dec;

  // table addressing
  logic [SW-1:0] rd_st;
  assign rd_st = (cmd_r == CMD_UPDATE) ? ns_r : cs_r;

  always_comb begin
    unique case (state_r)
      S_RD_A:  ram_raddr = {rd_st, 1'b0};
      S_RD_B:  ram_raddr = {rd_st, 1'b1};
      default: ram_raddr = {cs_r, act_r};
    endcase
  end

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_U_WB);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r : {cs_r, act_r};
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : nv_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    eps_nxt       = eps_r;
    qa_nxt        = qa_r;
    old_nxt       = old_r;
    diff_nxt      = diff_r;
    res_act_nxt   = res_act_r;
    res_exp_nxt   = res_exp_r;
    res_q_nxt     = res_q_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_act_nxt = 1'b0;
          res_exp_nxt = 1'b0;
          res_q_nxt   = '0;
          unique case (in_command)
            CMD_CHOOSE, CMD_UPDATE: state_nxt = S_RD_A;
            CMD_EPEND:              state_nxt = S_D_MUL1;
            default:                state_nxt = S_DONE;
          endcase
        end
      end
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: begin
        qa_nxt    = rd_q;
        state_nxt = (cmd_r == CMD_UPDATE) ? S_RD_C : S_C_PICK;
      end
      S_RD_C: state_nxt = S_U_DIFF;       // product of gamma and best value
      S_U_DIFF: begin
        old_nxt   = rd_q;
        diff_nxt  = reward_w + p_rnd[MUL_B_W-1:0] - old_w;
        state_nxt = S_U_MUL2;
      end
      S_U_MUL2: state_nxt = S_U_WB;
      S_U_WB: begin
        res_q_nxt = nv_sat;
        state_nxt = S_DONE;
      end
      S_C_PICK: begin
        res_exp_nxt = explore;
        res_act_nxt = explore ? ract_r : !(qa_r > rd_q);
        state_nxt   = S_DONE;
      end
      S_D_MUL1: state_nxt = S_D_MUL2;
      S_D_MUL2: state_nxt = S_D_FIN;
      S_D_FIN: begin
        eps_nxt   = eps_floor;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      eps_r         <= EPSILON_RST;
      learn_rate_r  <= LEARN_RATE_RST;
      discount_r    <= DISCOUNT_RST;
      min_explore_r <= MIN_EXPLORE_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      eps_r       <= eps_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LEARN_RATE:  learn_rate_r  <= cfg_data;
          CFG_DISCOUNT:    discount_r    <= cfg_data;
          CFG_MIN_EXPLORE: min_explore_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    qa_r      <= qa_nxt;
    old_r     <= old_nxt;
    diff_r    <= diff_nxt;
    res_act_r <= res_act_nxt;
    res_exp_r <= res_exp_nxt;
    res_q_r   <= res_q_nxt;
    if (in_valid && in_ready) begin
      cmd_r    <= in_command;
      cs_r     <= st_map[in_cur_state];
      ns_r     <= st_map[in_next_state];
      act_r    <= in_taken_action;
      reward_r <= in_reward_value;
      rpct_r   <= in_random_percent;
      ract_r   <= in_random_action;
    end
    if (out_load) begin
      out_act_r <= res_act_r;
      out_exp_r <= res_exp_r;
      out_q_r   <= res_q_r;
      out_eps_r <= eps_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_action = out_act_r;
  assign out_explored      = out_exp_r;
  assign out_q_result      = out_q_r;
  assign out_explore_rate  = out_eps_r;

  // checks
  a_accept_leaves_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted item did not start the sequencer");

  a_eps_floor : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_FIN && !cfg_valid) |=> (eps_r >= min_explore_r))
    else $error("exploration rate below floor after decay");

  a_explored_no_q : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_explored) |-> (out_q_result == '0))
    else $error("explore result carries a table value");

  a_no_clear_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> !(out_valid && !$past(out_valid)))
    else $error("result produced during table clear");

endmodule : tabular_q_learning_engine_core
`default_nettype wire

[dv/tabular_q_learning_engine_core_tb.sv]
// Testbench for the tabular Q-learning engine: directed and random commands against a predictor.
`timescale 1ns / 1ps

module tabular_q_learning_engine_core_tb
  import tqle_pkg::*;
;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int         DRAIN_SLACK = 10;
  localparam longint     Q_MAX       = 64'sh0000_0000_7FFF_FFFF;
  localparam longint     Q_MIN       = -64'sh0000_0000_8000_0000;

  typedef struct {
    logic [1:0]         cmd;
    logic [4:0]         cur_state;
    logic               act;
    logic signed [15:0] reward;
    logic [4:0]         next_state;
    logic [6:0]         pct;
    logic               rand_act;
  } engine_cmd_t;

  typedef struct {
    logic               chosen;
    logic               explored;
    logic signed [31:0] q;
    logic [15:0]        rate;
  } engine_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_command = '0;
  logic [4:0]         in_cur_state = '0;
  logic               in_taken_action = 1'b0;
  logic signed [15:0] in_reward_value = '0;
  logic [4:0]         in_next_state = '0;
  logic [6:0]         in_random_percent = '0;
  logic               in_random_action = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b1;
  logic               out_chosen_action;
  logic               out_explored;
  logic signed [31:0] out_q_result;
  logic [15:0]        out_explore_rate;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // predictor state
  logic signed [31:0] q_table [64];
  logic [15:0]        epsilon = EPSILON_RST;
  logic [15:0]        alpha = LEARN_RATE_RST;
  logic [15:0]        gamma = DISCOUNT_RST;
  logic [15:0]        eps_floor = MIN_EXPLORE_RST;

  engine_result_t pending_results [$];
  int             error_count = 0;
  bit             throttle_en = 1'b0;
  int             stall_left = 0;

  tabular_q_learning_engine_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_cur_state      (in_cur_state),
    .in_taken_action   (in_taken_action),
    .in_reward_value   (in_reward_value),
    .in_next_state     (in_next_state),
    .in_random_percent (in_random_percent),
    .in_random_action  (in_random_action),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_chosen_action (out_chosen_action),
    .out_explored      (out_explored),
    .out_q_result      (out_q_result),
    .out_explore_rate  (out_explore_rate),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    for (int i = 0; i < 64; i++) q_table[i] = '0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // floor((p + 2^15) / 2^16)
  function automatic longint round_q16(longint p);
    return (p + 32768) >>> 16;
  endfunction

  function automatic engine_result_t next_engine_result(engine_cmd_t c);
    engine_result_t r;
    logic [5:0]     slot;
    longint         old_q;
    longint         best_q;
    longint         new_q;
    r.chosen   = 1'b0;
    r.explored = 1'b0;
    r.q        = '0;
    case (c.cmd)
      CMD_CHOOSE: begin
        if (longint'(c.pct) * 65536 < longint'(epsilon) * PCT_SCALE) begin
          r.chosen   = c.rand_act;
          r.explored = 1'b1;
        end else begin
          // ties go to action 1
          r.chosen = (q_table[{c.cur_state, 1'b0}] > q_table[{c.cur_state, 1'b1}]) ? 1'b0 : 1'b1;
        end
      end
      CMD_UPDATE: begin
        slot   = {c.cur_state, c.act};
        old_q  = q_table[slot];
        best_q = (q_table[{c.next_state, 1'b0}] > q_table[{c.next_state, 1'b1}]) ?
                 q_table[{c.next_state, 1'b0}] : q_table[{c.next_state, 1'b1}];
        new_q  = longint'(c.reward) * 256 + round_q16(longint'(gamma) * best_q) - old_q;
        new_q  = old_q + round_q16(longint'(alpha) * new_q);
        if (new_q > Q_MAX) new_q = Q_MAX;
        if (new_q < Q_MIN) new_q = Q_MIN;
        q_table[slot] = 32'(new_q);
        r.q = q_table[slot];
      end
      CMD_EPEND: begin
        if (epsilon > eps_floor) epsilon = 16'((32'(epsilon) * 32'd995) / 32'd1000);
        if (epsilon < eps_floor) epsilon = eps_floor;
      end
      default: ;
    endcase
    r.rate = epsilon;
    return r;
  endfunction

  function automatic void note_mismatch(string field, logic signed [63:0] want,
                                        logic signed [63:0] got);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [4:0] cur, input logic act,
                           input logic signed [15:0] reward, input logic [4:0] nxt,
                           input logic [6:0] pct, input logic rand_act);
    engine_cmd_t c;
    int          gap;
    c.cmd        = cmd;
    c.cur_state  = cur;
    c.act        = act;
    c.reward     = reward;
    c.next_state = nxt;
    c.pct        = pct;
    c.rand_act   = rand_act;
    gap = (throttle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_cur_state      <= cur;
    in_taken_action   <= act;
    in_reward_value   <= reward;
    in_next_state     <= nxt;
    in_random_percent <= pct;
    in_random_action  <= rand_act;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(next_engine_result(c));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // only while the engine is idle
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LEARN_RATE:  alpha = data;
      CFG_DISCOUNT:    gamma = data;
      CFG_MIN_EXPLORE: eps_floor = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (throttle_en && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    engine_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unrequested result", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (out_chosen_action !== want.chosen)
          note_mismatch("chosen_action", want.chosen, out_chosen_action);
        if (out_explored !== want.explored)
          note_mismatch("explored", want.explored, out_explored);
        if (out_q_result !== want.q)
          note_mismatch("q_result", want.q, out_q_result);
        if (out_explore_rate !== want.rate)
          note_mismatch("explore_rate", want.rate, out_explore_rate);
      end
    end
  end

  // default rate: percent 10 still explores, 11 does not
  task automatic test_choose_at_reset();
    throttle_en = 1'b1;
    send_item(CMD_CHOOSE, 5'd0, 1'b0, 16'sd0, 5'd0, 7'd0, 1'b1);
    send_item(CMD_CHOOSE, 5'd31, 1'b1, 16'sd0, 5'd31, 7'd10, 1'b0);
    send_item(CMD_CHOOSE, 5'd31, 1'b0, 16'sd0, 5'd0, 7'd11, 1'b1);
    send_item(CMD_CHOOSE, 5'd0, 1'b0, 16'sd0, 5'd0, 7'd99, 1'b0);
    send_item(CMD_CHOOSE, 5'd0, 1'b0, 16'sd0, 5'd0, 7'd127, 1'b0);
  endtask

  task automatic test_update_extremes();
    throttle_en = 1'b1;
    send_item(CMD_UPDATE, 5'd0, 1'b0, 16'sh7FFF, 5'd31, 7'd0, 1'b0);
    send_item(CMD_UPDATE, 5'd0, 1'b1, -16'sh8000, 5'd0, 7'd0, 1'b0);
    send_item(CMD_UPDATE, 5'd31, 1'b1, 16'sd0, 5'd0, 7'd0, 1'b0);
    send_item(CMD_UPDATE, 5'd31, 1'b0, -16'sd1, 5'd31, 7'd0, 1'b0);
    send_item(CMD_UPDATE, 5'd0, 1'b0, 16'sh7FFF, 5'd0, 7'd0, 1'b0);
    send_item(CMD_CHOOSE, 5'd0, 1'b0, 16'sd0, 5'd0, 7'd127, 1'b1);
    send_item(CMD_CHOOSE, 5'd31, 1'b0, 16'sd0, 5'd0, 7'd127, 1'b0);
  endtask

  task automatic test_unused_command();
    throttle_en = 1'b0;
    send_item(CMD_UNUSED, 5'd31, 1'b1, -16'sd1, 5'd31, 7'd127, 1'b1);
    send_item(CMD_UNUSED, 5'd0, 1'b0, 16'sd0, 5'd0, 7'd0, 1'b0);
  endtask

  task automatic test_register_writes();
    wait_drained();
    write_reg(CFG_LEARN_RATE, 16'd0);
    write_reg(CFG_DISCOUNT, 16'hFFFF);
    write_reg(CFG_MIN_EXPLORE, 16'd0);
    write_reg(CFG_UNUSED, 16'h1234);
    throttle_en = 1'b1;
    // zero learning rate leaves the entry alone
    send_item(CMD_UPDATE, 5'd0, 1'b0, 16'sh7FFF, 5'd0, 7'd0, 1'b0);
    wait_drained();
    write_reg(CFG_LEARN_RATE, 16'hFFFF);
    write_reg(CFG_DISCOUNT, 16'd0);
    send_item(CMD_UPDATE, 5'd0, 1'b1, -16'sh8000, 5'd31, 7'd0, 1'b0);
  endtask

  task automatic test_explore_decay();
    wait_drained();
    // floor above the rate pulls it up
    write_reg(CFG_MIN_EXPLORE, 16'hFFFF);
    throttle_en = 1'b1;
    send_item(CMD_EPEND, 5'd0, 1'b0, 16'sd0, 5'd0, 7'd0, 1'b0);
    send_item(CMD_CHOOSE, 5'd3, 1'b0, 16'sd0, 5'd0, 7'd99, 1'b1);
    wait_drained();
    write_reg(CFG_MIN_EXPLORE, 16'd0);
    repeat (3) send_item(CMD_EPEND, 5'd0, 1'b0, 16'sd0, 5'd0, 7'd0, 1'b0);
    wait_drained();
    // rate already below the new floor is pulled up to it
    write_reg(CFG_MIN_EXPLORE, 16'd65000);
    repeat (2) send_item(CMD_EPEND, 5'd0, 1'b0, 16'sd0, 5'd0, 7'd0, 1'b0);
    wait_drained();
    write_reg(CFG_MIN_EXPLORE, MIN_EXPLORE_RST);
  endtask

  // self-loop with near-unity alpha and gamma drives both actions into the rails
  task automatic test_value_saturation();
    wait_drained();
    write_reg(CFG_LEARN_RATE, 16'hFFFF);
    write_reg(CFG_DISCOUNT, 16'hFFFF);
    throttle_en = 1'b1;
    for (int k = 0; k < 280; k++)
      send_item(CMD_UPDATE, 5'd5, k[0], 16'sh7FFF - 16'($urandom_range(0, 255)), 5'd5,
                7'($urandom), 1'($urandom));
    send_item(CMD_CHOOSE, 5'd5, 1'b0, 16'sd0, 5'd0, 7'd127, 1'b0);
    for (int k = 0; k < 280; k++)
      send_item(CMD_UPDATE, 5'd6, k[0], -16'sh8000 + 16'($urandom_range(0, 255)), 5'd6,
                7'($urandom), 1'($urandom));
    send_item(CMD_CHOOSE, 5'd6, 1'b0, 16'sd0, 5'd0, 7'd127, 1'b0);
  endtask

  task automatic test_random_traffic(input int count, input bit with_idle,
                                     input logic [15:0] a, input logic [15:0] g,
                                     input logic [15:0] f);
    int         pick;
    logic [1:0] cmd;
    logic [6:0] pct;
    wait_drained();
    write_reg(CFG_LEARN_RATE, a);
    write_reg(CFG_DISCOUNT, g);
    write_reg(CFG_MIN_EXPLORE, f);
    throttle_en = with_idle;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      cmd = CMD_CHOOSE;
      else if (pick < 80) cmd = CMD_UPDATE;
      else if (pick < 95) cmd = CMD_EPEND;
      else                cmd = CMD_UNUSED;
      pct = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
      send_item(cmd, 5'($urandom), 1'($urandom), 16'($urandom), 5'($urandom), pct,
                1'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_choose_at_reset();
    test_update_extremes();
    test_unused_command();
    test_register_writes();
    test_explore_decay();
    test_value_saturation();
    test_random_traffic(160, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom_range(0, 4000)));
    test_random_traffic(160, 1'b0, 16'hFFFF, 16'd0, 16'd0);
    test_random_traffic(160, 1'b1, 16'($urandom), 16'hFFFF, 16'($urandom));
    wait_drained();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
